[rtl/sc16_pkg.sv]
package sc16_pkg;

  localparam int MAG_W  = 16;
  localparam int SIG_W  = 53;
  localparam int HI_W   = 27;
  localparam int LO_W   = SIG_W - HI_W;
  localparam int PROD_W = MAG_W + SIG_W;

  localparam logic [63:0] SCALE_RESET = 64'h3F00000000000000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8000000000000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008000000000000;
  localparam logic [10:0] EXP_MAX     = 11'h7FF;

  // Register select: byte address bit 3 (scale at 0x0, byte order at 0x8)
  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_ENDIAN = 1'b1;

  typedef struct packed {
    logic [31:0] raw_word;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [63:0] real_bits;
    logic [63:0] imag_bits;
    logic        last_out;
  } out_t;

  // per-part info that rides along with the arithmetic
  typedef struct packed {
    logic        neg;
    logic        spec;
    logic [63:0] spec_bits;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [MAG_W-1:0] mag;
  } lane1_t;

  typedef struct packed {
    logic            valid;
    logic            last;
    lane1_t [1:0]    lane;
  } s1_t;

  typedef struct packed {
    tag_t                   tag;
    logic [MAG_W+HI_W-1:0]  p_hi;
    logic [MAG_W+LO_W-1:0]  p_lo;
  } lane2_t;

  typedef struct packed {
    logic          valid;
    logic          last;
    lane2_t [1:0]  lane;
  } s2_t;

  typedef struct packed {
    tag_t              tag;
    logic [PROD_W-1:0] prod;
  } lane3_t;

  typedef struct packed {
    logic          valid;
    logic          last;
    lane3_t [1:0]  lane;
  } s3_t;

  // scale operand as seen by the datapath
  typedef struct packed {
    logic [SIG_W-1:0] sig;
    logic [10:0]      exp_eff;
  } scale_t;

  function automatic logic [6:0] lzc_prod(input logic [PROD_W-1:0] p);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < PROD_W; i++) begin
      if (p[i]) n = 7'(PROD_W - 1 - i);
    end
    return n;
  endfunction

endpackage

[rtl/sc16_to_fc64_converter.sv]
// Complex int16 sample to complex double converter.
// Input channel (in_valid/in_ready/in_data): one 32-bit word per request
// holding two signed 16-bit parts plus a last flag. Output channel
// (out_valid/out_ready/out_data): real and imaginary IEEE doubles, each the
// part times the scale register, rounded to nearest even, plus the last flag.
// APB port: scale at 0x0 (64-bit double pattern), byte order at 0x8 (bit 0,
// 1 = big-endian layout, parts byte-swapped, real in the first two bytes).
// Throughput: one request per clock unless out_ready stalls the pipe.
// Stages: unpack/classify, partial products, product sum,
// leading-zero count, normalize shift, round/pack (output register).
// A stalled out_ready freezes the whole pipe; in_ready drops with it, so no
// request is lost or repeated. Reset clears all stage valids, loads the scale
// with 2^-15 and selects little-endian layout. Registers are meant to be
// written only while the pipe is empty.
module sc16_to_fc64_converter import sc16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  // output stream
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] scale_r;
  logic        big_endian_r;
  logic        en;
  logic        wr;
  scale_t      scale;
  s1_t         s1;
  s3_t         s3;

  // config registers; low address bits are ignored (word aligned)
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= SCALE_RESET;
      big_endian_r <= 1'b0;
    end else if (wr) begin
      case (paddr[3])
        REG_SCALE:  scale_r      <= pwdata;
        REG_ENDIAN: big_endian_r <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_SCALE:  prdata = scale_r;
      REG_ENDIAN: prdata = {63'd0, big_endian_r};
      default:    prdata = '0;
    endcase
  end

  // scale operand: subnormals use exponent 1 and no hidden bit
  assign scale.sig     = {(scale_r[62:52] != 11'd0), scale_r[51:0]};
  assign scale.exp_eff = (scale_r[62:52] == 11'd0) ? 11'd1 : scale_r[62:52];

  // whole pipe advances unless the output holds an untaken result
  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  sc16_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .big_endian (big_endian_r),
    .scale_bits (scale_r),
    .s1         (s1)
  );

  sc16_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .s1    (s1),
    .scale (scale),
    .s3    (s3)
  );

  sc16_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .s3        (s3),
    .scale     (scale),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/sc16_unpack.sv]
module sc16_unpack import sc16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  in_t         in_data,
  input  logic        big_endian,
  input  logic [63:0] scale_bits,
  output s1_t         s1
);

  s1_t         s1_r, s1_nxt;
  logic [15:0] part [2];
  logic        s_nan, s_inf, s_zero;

  assign s_nan  = (scale_bits[62:52] == EXP_MAX) && (scale_bits[51:0] != '0);
  assign s_inf  = (scale_bits[62:52] == EXP_MAX) && (scale_bits[51:0] == '0);
  assign s_zero = (scale_bits[62:0] == '0);

  always_comb begin
    if (big_endian) begin
      part[0] = {in_data.raw_word[7:0], in_data.raw_word[15:8]};
      part[1] = {in_data.raw_word[23:16], in_data.raw_word[31:24]};
    end else begin
      part[0] = in_data.raw_word[31:16];
      part[1] = in_data.raw_word[15:0];
    end
  end

  always_comb begin
    s1_nxt       = s1_r;
    s1_nxt.valid = in_valid;
    s1_nxt.last  = in_data.last_in;
    for (int k = 0; k < 2; k++) begin
      s1_nxt.lane[k].tag.neg = part[k][15];
      s1_nxt.lane[k].mag     = part[k][15] ? (~part[k] + 16'd1) : part[k];
      s1_nxt.lane[k].tag.spec      = 1'b1;
      if (s_nan) begin
        s1_nxt.lane[k].tag.spec_bits = scale_bits | QUIET_BIT;
      end else if (s_inf && part[k] == '0) begin
        s1_nxt.lane[k].tag.spec_bits = DEFAULT_NAN;
      end else if (s_inf) begin
        s1_nxt.lane[k].tag.spec_bits = {scale_bits[63] ^ part[k][15], EXP_MAX, 52'd0};
      end else if (s_zero || part[k] == '0) begin
        s1_nxt.lane[k].tag.spec_bits = {scale_bits[63] ^ part[k][15], 63'd0};
      end else begin
        s1_nxt.lane[k].tag.spec      = 1'b0;
        s1_nxt.lane[k].tag.spec_bits = '0;
      end
      s1_nxt.lane[k].tag.neg = scale_bits[63] ^ part[k][15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

[rtl/sc16_mul.sv]
module sc16_mul import sc16_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  s1_t    s1,
  input  scale_t scale,
  output s3_t    s3
);

  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;

  // two partial products per part, summed one stage later
  always_comb begin
    s2_nxt       = s2_r;
    s2_nxt.valid = s1.valid;
    s2_nxt.last  = s1.last;
    for (int k = 0; k < 2; k++) begin
      s2_nxt.lane[k].tag  = s1.lane[k].tag;
      s2_nxt.lane[k].p_hi = s1.lane[k].mag * scale.sig[SIG_W-1:LO_W];
      s2_nxt.lane[k].p_lo = s1.lane[k].mag * scale.sig[LO_W-1:0];
    end
  end

  always_comb begin
    s3_nxt       = s3_r;
    s3_nxt.valid = s2_r.valid;
    s3_nxt.last  = s2_r.last;
    for (int k = 0; k < 2; k++) begin
      s3_nxt.lane[k].tag  = s2_r.lane[k].tag;
      s3_nxt.lane[k].prod = {s2_r.lane[k].p_hi, {LO_W{1'b0}}}
                          + PROD_W'(s2_r.lane[k].p_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

[rtl/sc16_norm.sv]
module sc16_norm import sc16_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  s3_t    s3,
  input  scale_t scale,
  output logic   out_valid,
  output out_t   out_data
);

  // stage 4: leading zero count
  logic              v4_r, l4_r;
  tag_t              t4_r   [2];
  logic [PROD_W-1:0] p4_r   [2];
  logic [6:0]        lz4_r  [2];
  // stage 5: shift and exponent
  logic              v5_r, l5_r;
  tag_t              t5_r   [2];
  logic [PROD_W-1:0] sh5_r  [2];
  logic [10:0]       ef5_r  [2];
  logic              ovf5_r [2];
  // stage 6: rounded result
  logic              v6_r;
  out_t              o6_r, o6_nxt;

  logic signed [12:0] re     [2];
  logic [6:0]         sh_amt [2];
  logic [62:0]        rmag   [2];
  logic [63:0]        res    [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      re[k] = $signed({2'b00, scale.exp_eff}) + 13'sd16 - $signed({6'd0, lz4_r[k]});
      // subnormal result: stop the shift where the exponent field hits zero
      sh_amt[k] = (re[k] >= 13'sd1) ? lz4_r[k] : 7'(scale.exp_eff + 11'd15);
    end
  end

  always_comb begin
    o6_nxt          = o6_r;
    o6_nxt.last_out = l5_r;
    for (int k = 0; k < 2; k++) begin
      rmag[k] = {ef5_r[k], sh5_r[k][PROD_W-2:PROD_W-53]}
              + 63'(sh5_r[k][PROD_W-54] &
                    ((|sh5_r[k][PROD_W-55:0]) | sh5_r[k][PROD_W-53]));
      if (t5_r[k].spec) begin
        res[k] = t5_r[k].spec_bits;
      end else if (ovf5_r[k]) begin
        res[k] = {t5_r[k].neg, EXP_MAX, 52'd0};
      end else begin
        res[k] = {t5_r[k].neg, rmag[k]};
      end
    end
    o6_nxt.real_bits = res[0];
    o6_nxt.imag_bits = res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= s3.valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l4_r <= s3.last;
      l5_r <= l4_r;
      o6_r <= o6_nxt;
      for (int k = 0; k < 2; k++) begin
        t4_r[k]   <= s3.lane[k].tag;
        p4_r[k]   <= s3.lane[k].prod;
        lz4_r[k]  <= lzc_prod(s3.lane[k].prod);
        t5_r[k]   <= t4_r[k];
        sh5_r[k]  <= p4_r[k] << sh_amt[k];
        ef5_r[k]  <= (re[k] >= 13'sd1) ? re[k][10:0] : 11'd0;
        ovf5_r[k] <= (re[k] >= 13'sd2047);
      end
    end
  end

  assign out_valid = v6_r;
  assign out_data  = o6_r;

endmodule

[tb/tb_sc16_to_fc64_converter.sv]
`timescale 1ns / 1ps

module tb_sc16_to_fc64_converter;
  import sc16_pkg::*;

  // Byte addresses of the two registers (64-bit wide, so 8 bytes apart)
  localparam logic [3:0] ADDR_SCALE  = 4'h0;
  localparam logic [3:0] ADDR_ENDIAN = 4'h8;

  localparam int DRAIN_CYCLES = 12;     // longer than the pipe latency
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_REQS  = 850;

  // Double patterns used for the directed scale settings
  localparam logic [63:0] DBL_ONE      = 64'h3FF0000000000000;
  localparam logic [63:0] DBL_NEG_ONE  = 64'hBFF0000000000000;
  localparam logic [63:0] DBL_POS_INF  = 64'h7FF0000000000000;
  localparam logic [63:0] DBL_NEG_INF  = 64'hFFF0000000000000;
  localparam logic [63:0] DBL_SNAN     = 64'h7FF0000000000001;
  localparam logic [63:0] DBL_NEG_QNAN = 64'hFFF8000000000123;
  localparam logic [63:0] DBL_POS_ZERO = 64'h0000000000000000;
  localparam logic [63:0] DBL_NEG_ZERO = 64'h8000000000000000;
  localparam logic [63:0] DBL_MAX      = 64'h7FEFFFFFFFFFFFFF;
  localparam logic [63:0] DBL_MIN_NORM = 64'h0010000000000000;
  localparam logic [63:0] DBL_MIN_SUB  = 64'h0000000000000001;
  localparam logic [63:0] DBL_NEG_SCL  = 64'hBF00000000000000;
  localparam logic [63:0] DBL_ONE_3RD  = 64'h3FD5555555555555;

  localparam logic [63:0] EXP_FIELD = 64'h7FF0000000000000;
  localparam logic [63:0] MAN_FIELD = 64'h000FFFFFFFFFFFFF;

  // Expected-sample store plus its own copy of the two registers
  class sample_scoreboard;
    logic [63:0] scale;
    logic        swap_bytes;
    out_t        pending[$];
    int          checked;

    function new();
      scale      = SCALE_RESET;
      swap_bytes = 1'b0;
      checked    = 0;
    endfunction

    function logic [63:0] scaled_part(logic [15:0] h);
      int          v;
      logic [63:0] r;
      v = $signed(h);
      if ((scale & EXP_FIELD) == EXP_FIELD && (scale & MAN_FIELD) != 0)
        r = scale | QUIET_BIT;
      else if ((scale & EXP_FIELD) == EXP_FIELD && v == 0)
        r = DEFAULT_NAN;
      else
        r = $realtobits(real'(v) * $bitstoreal(scale));
      return r;
    endfunction

    function void note_request(in_t req);
      out_t        e;
      logic [15:0] re;
      logic [15:0] im;
      if (swap_bytes) begin
        re = {req.raw_word[7:0], req.raw_word[15:8]};
        im = {req.raw_word[23:16], req.raw_word[31:24]};
      end else begin
        re = req.raw_word[31:16];
        im = req.raw_word[15:0];
      end
      e.real_bits = scaled_part(re);
      e.imag_bits = scaled_part(im);
      e.last_out  = req.last_in;
      pending.push_back(e);
    endfunction

    // returns an empty string when the sample matches
    function string check_sample(out_t got);
      out_t  e;
      string msg;
      checked++;
      if (pending.size() == 0)
        return $sformatf("unexpected sample re=%h im=%h last=%b",
                         got.real_bits, got.imag_bits, got.last_out);
      e   = pending.pop_front();
      msg = "";
      if (got.real_bits !== e.real_bits)
        msg = {msg, $sformatf(" real got %h exp %h", got.real_bits, e.real_bits)};
      if (got.imag_bits !== e.imag_bits)
        msg = {msg, $sformatf(" imag got %h exp %h", got.imag_bits, e.imag_bits)};
      if (got.last_out !== e.last_out)
        msg = {msg, $sformatf(" last got %b exp %b", got.last_out, e.last_out)};
      if (msg != "") msg = $sformatf("sample %0d:%s", checked, msg);
      return msg;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  sample_scoreboard sb;
  int  errors;
  int  cycles;
  int  accepted;
  bit  idle_on;     // random gaps on both sides when set
  int  hold_req;    // receiver back-pressure request, in cycles
  int  cfg_writes;

  sc16_to_fc64_converter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    errors++;
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples pending",
               cycles, sb.pending.size());
      $display("[sc16_to_fc64_converter] ERROR");
      $finish;
    end
  end

  // Monitor: values seen here are the ones from before the edge
  always @(posedge clk) begin
    string msg;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_data);
        accepted++;
      end
      if (out_valid && out_ready) begin
        msg = sb.check_sample(out_data);
        if (msg != "") report(msg);
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold     = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 16);
      end
    end
  end

  // Send one request; returns after the accepting edge and any idle gap
  task automatic send_req(logic [31:0] word, logic last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{raw_word: word, last_in: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // random gaps keep the sender idle ~16% of the time
    if (idle_on && $urandom_range(99) < 8) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let the pipe empty so a register write never lands on a live sample
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access, register taken at the access edge
  task automatic reg_write(logic [3:0] addr, logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_SCALE) sb.scale = data;
    else if (addr == ADDR_ENDIAN) sb.swap_bytes = data[0];
    cfg_writes++;
  endtask

  task automatic set_mode(logic [63:0] scale, logic [63:0] endian_word);
    wait_drained();
    reg_write(ADDR_SCALE, scale);
    reg_write(ADDR_ENDIAN, endian_word);
  endtask

  // Corner words: zero, all ones, both most negative, both most positive,
  // mixed signs, and byte patterns that change meaning under the swap
  task automatic send_corners();
    send_req(32'h00000000, 1'b0);
    send_req(32'hFFFFFFFF, 1'b1);
    send_req(32'h80008000, 1'b0);
    send_req(32'h7FFF7FFF, 1'b0);
    send_req(32'h80007FFF, 1'b1);
    send_req(32'h00800080, 1'b0);
    send_req(32'h12345678, 1'b0);
    send_req(32'h00010000, 1'b1);
  endtask

  function automatic logic [15:0] pick_half();
    logic [15:0] h;
    case ($urandom_range(7))
      0: h = 16'h0000;
      1: h = 16'h7FFF;
      2: h = 16'h8000;
      3: h = 16'hFFFF;
      4: h = 16'h0001;
      default: h = 16'($urandom);
    endcase
    return h;
  endfunction

  function automatic logic [63:0] pick_scale();
    logic [63:0] s;
    case ($urandom_range(5))
      0: s = {$urandom, $urandom};
      1: s = {2'b00, 10'($urandom), 52'({$urandom, $urandom})};  // small magnitude
      2: s = {1'b1, 11'h3F0, 52'({$urandom, $urandom})};
      3: s = {1'b0, 11'h7FE, 52'({$urandom, $urandom})};          // may overflow
      default: s = {1'($urandom), 11'($urandom_range(960, 1080)),
                    52'({$urandom, $urandom})};
    endcase
    return s;
  endfunction

  initial begin
    logic [63:0] dir_scales[12];
    logic [31:0] w;
    string       msg;

    sb = new();
    errors = 0;
    cycles = 0;
    accepted = 0;
    idle_on = 1'b0;
    hold_req = 0;
    cfg_writes = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset setting, then byte-swapped layout
    send_corners();
    set_mode(SCALE_RESET, 64'h1);
    send_corners();

    // Special scales: NaNs pass through quieted, inf times zero gives the
    // default NaN, zero parts keep the sign rules, extremes over/underflow
    dir_scales = '{DBL_ONE, DBL_NEG_ONE, DBL_POS_INF, DBL_NEG_INF, DBL_SNAN,
                   DBL_NEG_QNAN, DBL_POS_ZERO, DBL_NEG_ZERO, DBL_MAX,
                   DBL_MIN_NORM, DBL_MIN_SUB, 64'hFFFFFFFFFFFFFFFF};
    foreach (dir_scales[i]) begin
      // upper bits of the byte-order word must be ignored
      set_mode(dir_scales[i], (i % 2) ? 64'hFFFFFFFFFFFFFFFE : 64'h1);
      send_req(32'h00007FFF, 1'b0);
      send_req(32'h80000001, 1'b1);
    end
    $display("directed part done, %0d requests", accepted);

    // Random part: five settings, idling with a no-idle stretch in the middle
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_mode(SCALE_RESET, 64'h0);
        1: set_mode(DBL_NEG_SCL, 64'h1);
        2: set_mode(DBL_ONE_3RD, {$urandom, $urandom} & ~64'h1);
        3: set_mode(DBL_MAX, 64'h1);
        default: set_mode(pick_scale(), {$urandom, $urandom});
      endcase
      for (int k = 0; k < RANDOM_REQS / 5; k++) begin
        idle_on = !(ph == 2 && k < 120);
        // long receiver hold-off so the pipe backs up onto in_ready
        if (ph == 1 && k == 40) hold_req = 60;
        if ($urandom_range(3) == 0) w = $urandom;
        else w = {pick_half(), pick_half()};
        send_req(w, $urandom_range(7) == 0);
      end
    end

    wait_drained();
    while (sb.pending.size() != 0) begin
      msg = $sformatf("expected sample never arrived re=%h",
                      sb.pending[0].real_bits);
      void'(sb.pending.pop_front());
      report(msg);
    end

    $display("covered %0d requests, %0d samples checked, %0d register writes",
             accepted, sb.checked, cfg_writes);
    $display("both layouts, special and random scales, stalls on both sides");
    if (errors == 0) begin
      $display("[sc16_to_fc64_converter] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[sc16_to_fc64_converter] ERROR");
    end
    $finish;
  end

endmodule
